FILE: hw/rtl/cst_pkg.sv
// cst_pkg: request, response and table-record types, status and kind codes,
// and fixed constants for the client session tracker.
// No dependencies.
`timescale 1ns / 1ps

package cst_pkg;

	localparam int KEY_W     = 32;
	localparam int TIME_W    = 32;
	localparam int GAP_W     = 16;
	localparam int VISITS_W  = 16;
	localparam int RIDX_W    = 9;
	localparam int CNT_OUT_W = 10;
	localparam int HOURS_W   = 21;
	localparam int STATUS_W  = 2;

	localparam logic [GAP_W-1:0]    GAP_RESET    = 16'd32;
	localparam int                  SEC_PER_HOUR = 3600;
	localparam int                  HALF_HOUR    = 30 * 60;
	localparam logic [VISITS_W-1:0] VISITS_MAX   = '1;
	localparam logic [TIME_W-1:0]   TIME_MAX     = '1;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	localparam logic KIND_HIT  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [KEY_W-1:0]  client_key;
		logic [TIME_W-1:0] timestamp;
		logic [RIDX_W-1:0] read_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [RIDX_W-1:0]    entry_index;
		logic                 new_client;
		logic                 new_session;
		logic [KEY_W-1:0]     entry_key;
		logic [VISITS_W-1:0]  visit_count;
		logic [TIME_W-1:0]    elapsed_seconds;
		logic [HOURS_W-1:0]   elapsed_hours;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_t;

	// one table entry apart from its key
	typedef struct packed {
		logic                sess_open;
		logic [VISITS_W-1:0] visits;
		logic [TIME_W-1:0]   acc_time;
		logic [TIME_W-1:0]   last_seen;
		logic [TIME_W-1:0]   sess_start;
	} rec_t;

endpackage

FILE: hw/rtl/cst_ram.sv
// cst_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: hw/rtl/cst_div.sv
// cst_div: turns seconds into rounded hours by a reciprocal multiply,
// registered in y_s1 and then in prod_s2 from start to done.
// Depends on cst_pkg.
`timescale 1ns / 1ps

module cst_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cst_pkg::TIME_W-1:0]  seconds,
	output logic                        done,
	output logic [cst_pkg::HOURS_W-1:0] hours
);

	// 3600 = 16 * 225: drop four bits, then multiply by 2^36 / 225 rounded up
	localparam int     RW    = cst_pkg::TIME_W + 1;
	localparam int     PRE   = 4;
	localparam int     YW    = RW - PRE;
	localparam int     PW    = 2 * YW;
	localparam int     RSH   = 36;
	localparam longint DVR   = longint'(cst_pkg::SEC_PER_HOUR >> PRE);
	localparam logic [YW-1:0] RECIP =
		YW'(((longint'(1) << RSH) + DVR - longint'(1)) / DVR);

	logic [RW-1:0] rounded;
	logic [YW-1:0] y_s1;
	logic [PW-1:0] prod_s2;
	logic          v_s1;
	logic          v_s2;

	assign rounded = RW'(seconds) + RW'(cst_pkg::HALF_HOUR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			if (start) begin
				y_s1 <= rounded[RW-1:PRE];
			end
			if (v_s1) begin
				prod_s2 <= PW'(y_s1) * PW'(RECIP);
			end
		end
	end

	assign done  = v_s2;
	assign hours = prod_s2[RSH +: cst_pkg::HOURS_W];

endmodule

FILE: hw/rtl/client_session_tracker.sv
// client_session_tracker: session table keyed by client address, with a
// sequencer walking the key RAM and a shared hours divider.
// Depends on cst_pkg, cst_ram, cst_div.
`timescale 1ns / 1ps
//
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  cst_pkg::req_t
// rsp       out        rsp_valid / rsp_ready  cst_pkg::rsp_t
// cfg       in         cfg_we                 cfg_wdata (session gap, seconds)
//
// Hit: the key search compares one stored key per cycle; a match then reads,
// checks, applies and writes the record, and S_DIV waits for the hours multiply.
// A miss adds the entry in S_NEW, a full table gives ST_FULL. Read: as a match,
// or S_DONE if out of range. One request at a time; req_ready is high when idle.
// The response register holds a finished result while the next request runs.
// Reset empties the table at once (entry count to zero, gap to 32 s).

module client_session_tracker #(
	parameter int TABLE_DEPTH = 512
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_ready,
	input  cst_pkg::req_t             req,
	output logic                      rsp_valid,
	input  logic                      rsp_ready,
	output cst_pkg::rsp_t             rsp,
	input  logic                      cfg_we,
	input  logic [cst_pkg::GAP_W-1:0] cfg_wdata
);

	localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int TW  = cst_pkg::TIME_W;
	localparam int RCW = $bits(cst_pkg::rec_t);

	typedef enum logic [3:0] {
		S_IDLE, S_SEARCH, S_REC_RD, S_REC_CHK, S_APPLY, S_WRITE, S_NEW, S_DIV, S_DONE
	} state_t;

	state_t                    state_q;
	cst_pkg::req_t             req_q;
	cst_pkg::rsp_t             res_q;
	cst_pkg::rsp_t             rsp_q;
	logic                      rsp_valid_q;
	logic [CW-1:0]             used_q;
	logic [CW-1:0]             rd_idx_q;
	logic                      cmp_v_q;
	logic [IW-1:0]             cmp_idx_q;
	logic [IW-1:0]             e_q;
	cst_pkg::rec_t             rec_q;
	logic [TW-1:0]             span_q;
	logic [TW-1:0]             sum_q;
	logic                      gap_hit_q;
	logic [cst_pkg::GAP_W-1:0] gap_q;

	logic                          key_we;
	logic [IW-1:0]                 key_raddr;
	logic [cst_pkg::KEY_W-1:0]     key_rdata;
	logic                          rec_we;
	cst_pkg::rec_t                 rec_wdata;
	cst_pkg::rec_t                 rec_rdata;
	cst_pkg::rec_t                 upd_rec;
	cst_pkg::rec_t                 new_rec;
	logic                          do_close;
	logic                          do_open;
	logic                          key_match;
	logic                          cmp_last;
	logic                          div_start;
	logic [TW-1:0]                 div_secs;
	logic                          div_done;
	logic [cst_pkg::HOURS_W-1:0]   div_hours;
	logic [TW:0]                   sum_wide;
	logic [TW:0]                   gap_lim;
	cst_pkg::rsp_t                 idle_res;
	cst_pkg::rsp_t                 rsp_next;
	logic                          rsp_load;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= cst_pkg::GAP_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_wdata;
		end
	end

	assign key_match = cmp_v_q && (key_rdata == req_q.client_key);
	assign cmp_last  = (CW'(cmp_idx_q) + CW'(1)) == used_q;
	assign sum_wide  = {1'b0, rec_q.acc_time} + {1'b0, span_q};
	assign gap_lim   = {1'b0, rec_q.last_seen} + (TW + 1)'(gap_q);
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	// record update for a hit on a known key or a read
	always_comb begin
		if (req_q.kind == cst_pkg::KIND_READ) begin
			do_close = rec_q.sess_open;
			do_open  = 1'b0;
		end else begin
			do_close = rec_q.sess_open && gap_hit_q;
			do_open  = !rec_q.sess_open || gap_hit_q;
		end
		upd_rec = rec_q;
		if (do_close) begin
			upd_rec.acc_time  = sum_q;
			upd_rec.sess_open = 1'b0;
		end
		if (do_open) begin
			upd_rec.sess_start = req_q.timestamp;
			upd_rec.last_seen  = req_q.timestamp;
			upd_rec.sess_open  = 1'b1;
			if (rec_q.visits != cst_pkg::VISITS_MAX) begin
				upd_rec.visits = rec_q.visits + cst_pkg::VISITS_W'(1);
			end
		end else if (req_q.kind == cst_pkg::KIND_HIT) begin
			upd_rec.last_seen = req_q.timestamp;
		end
	end

	always_comb begin
		new_rec.sess_open  = 1'b1;
		new_rec.visits     = cst_pkg::VISITS_W'(1);
		new_rec.acc_time   = '0;
		new_rec.last_seen  = req_q.timestamp;
		new_rec.sess_start = req_q.timestamp;
	end

	// result at accept (only a read out of range is final here) and at send
	always_comb begin
		idle_res = '0;
		if ((req.kind == cst_pkg::KIND_READ) && (32'(req.read_index) >= 32'(used_q))) begin
			idle_res.status      = cst_pkg::ST_RANGE;
			idle_res.entry_index = req.read_index;
		end
		rsp_next             = res_q;
		rsp_next.entry_count = cst_pkg::CNT_OUT_W'(used_q);
	end

	always_comb begin
		key_raddr = (state_q == S_SEARCH) ? IW'(rd_idx_q) : e_q;
		key_we    = state_q == S_NEW;
		rec_we    = (state_q == S_NEW) || (state_q == S_WRITE);
		rec_wdata = (state_q == S_NEW) ? new_rec : upd_rec;
		div_start = rec_we;
		div_secs  = (state_q == S_NEW) ? '0 : upd_rec.acc_time;
	end

	cst_ram #(
		.WIDTH(cst_pkg::KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(e_q),
		.wdata(req_q.client_key),
		.raddr(key_raddr),
		.rdata(key_rdata)
	);

	cst_ram #(
		.WIDTH(RCW),
		.DEPTH(TABLE_DEPTH)
	) u_rec_ram (
		.clk  (clk),
		.we   (rec_we),
		.waddr(e_q),
		.wdata(rec_wdata),
		.raddr(e_q),
		.rdata(rec_rdata)
	);

	cst_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.seconds(div_secs),
		.done   (div_done),
		.hours  (div_hours)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			rsp_valid_q <= 1'b0;
			cmp_v_q     <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q <= req;
						res_q <= idle_res;
						if (req.kind == cst_pkg::KIND_READ) begin
							if (32'(req.read_index) >= 32'(used_q)) begin
								state_q <= S_DONE;
							end else begin
								e_q     <= IW'(req.read_index);
								state_q <= S_REC_RD;
							end
						end else if (used_q == '0) begin
							e_q     <= '0;
							state_q <= S_NEW;
						end else begin
							rd_idx_q <= '0;
							cmp_v_q  <= 1'b0;
							state_q  <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					// issue one key read and compare the previous one each cycle
					cmp_v_q   <= (rd_idx_q < used_q) && !key_match;
					cmp_idx_q <= IW'(rd_idx_q);
					if (rd_idx_q < used_q) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (key_match) begin
						e_q     <= cmp_idx_q;
						state_q <= S_REC_RD;
					end else if (cmp_v_q && cmp_last) begin
						if (used_q == CW'(TABLE_DEPTH)) begin
							res_q.status <= cst_pkg::ST_FULL;
							state_q      <= S_DONE;
						end else begin
							e_q     <= IW'(used_q);
							state_q <= S_NEW;
						end
					end
				end
				S_REC_RD: begin
					state_q <= S_REC_CHK;
				end
				S_REC_CHK: begin
					rec_q           <= rec_rdata;
					res_q.entry_key <= key_rdata;
					if (rec_rdata.last_seen >= rec_rdata.sess_start) begin
						span_q <= rec_rdata.last_seen - rec_rdata.sess_start;
					end else begin
						span_q <= '0;
					end
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					gap_hit_q <= gap_lim < {1'b0, req_q.timestamp};
					sum_q     <= sum_wide[TW] ? cst_pkg::TIME_MAX : sum_wide[TW-1:0];
					state_q   <= S_WRITE;
				end
				S_WRITE: begin
					res_q.entry_index     <= cst_pkg::RIDX_W'(e_q);
					res_q.new_session     <= do_open;
					res_q.visit_count     <= upd_rec.visits;
					res_q.elapsed_seconds <= upd_rec.acc_time;
					state_q               <= S_DIV;
				end
				S_NEW: begin
					used_q                <= used_q + CW'(1);
					res_q.entry_index     <= cst_pkg::RIDX_W'(e_q);
					res_q.new_client      <= 1'b1;
					res_q.new_session     <= 1'b1;
					res_q.entry_key       <= req_q.client_key;
					res_q.visit_count     <= new_rec.visits;
					res_q.elapsed_seconds <= '0;
					state_q               <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						res_q.elapsed_hours <= div_hours;
						state_q             <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q   <= rsp_next;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_ready = state_q == S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> (used_q == $past(used_q) + CW'(1)) && ($past(state_q) == S_NEW))
		else $error("entry count moved other than by one new entry");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside its wait state");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.status == cst_pkg::ST_FULL)
			|-> rsp_q.entry_count == cst_pkg::CNT_OUT_W'(TABLE_DEPTH))
		else $error("table full reported with room left");

endmodule

FILE: tb/client_session_tracker_tb.sv
`timescale 1ns / 1ps
// client_session_tracker_tb: sends hit and read requests into the session table and checks
// every report against a session table kept in the bench, field by field.
// Depends on cst_pkg and client_session_tracker.

module client_session_tracker_tb;
	import cst_pkg::*;

	localparam int DEPTH            = 512;
	localparam int RANDOM_PER_PHASE = 190;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_ready;
	req_t             req       = '0;
	logic             rsp_valid;
	logic             rsp_ready = 1'b0;
	rsp_t             rsp;
	logic             cfg_we    = 1'b0;
	logic [GAP_W-1:0] cfg_wdata = '0;

	client_session_tracker dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the session table
	logic [KEY_W-1:0]    tbl_key    [DEPTH];
	logic [TIME_W-1:0]   tbl_start  [DEPTH];
	logic [TIME_W-1:0]   tbl_seen   [DEPTH];
	logic [TIME_W-1:0]   tbl_total  [DEPTH];
	logic [VISITS_W-1:0] tbl_visits [DEPTH];
	bit                  tbl_open   [DEPTH];
	int                  tbl_used = 0;
	logic [GAP_W-1:0]    gap_now  = GAP_RESET;

	req_t              queued_requests[$];
	rsp_t              due_reports[$];
	logic [KEY_W-1:0]  known_keys[$];
	logic [TIME_W-1:0] key_clock[logic [KEY_W-1:0]];
	rsp_t              next_report;
	bit                failed = 1'b0;
	bit                steady = 1'b0;

	function automatic void end_session(int e);
		logic [TIME_W:0]   sum;
		logic [TIME_W-1:0] span;
		span = (tbl_seen[e] >= tbl_start[e]) ? tbl_seen[e] - tbl_start[e] : '0;
		sum = {1'b0, tbl_total[e]} + {1'b0, span};
		tbl_total[e] = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
		tbl_open[e] = 1'b0;
	endfunction

	function automatic void begin_session(int e, logic [TIME_W-1:0] t);
		tbl_start[e] = t;
		tbl_seen[e] = t;
		tbl_open[e] = 1'b1;
		if (tbl_visits[e] != VISITS_MAX)
			tbl_visits[e] = tbl_visits[e] + 1'b1;
	endfunction

	function automatic rsp_t entry_report(int e);
		rsp_t        o;
		logic [63:0] secs;
		o = '0;
		secs = 64'(tbl_total[e]) + 64'(HALF_HOUR);
		o.entry_index = RIDX_W'(e);
		o.entry_key = tbl_key[e];
		o.visit_count = tbl_visits[e];
		o.elapsed_seconds = tbl_total[e];
		o.elapsed_hours = HOURS_W'(secs / 64'(SEC_PER_HOUR));
		return o;
	endfunction

	function automatic rsp_t advance_sessions(req_t r);
		rsp_t o;
		int   e;
		logic opened;
		o = '0;
		if (r.kind == KIND_READ) begin
			if (int'(r.read_index) >= tbl_used) begin
				o.status = ST_RANGE;
				o.entry_index = r.read_index;
			end else begin
				if (tbl_open[r.read_index])
					end_session(r.read_index);
				o = entry_report(r.read_index);
			end
		end else begin
			e = 0;
			while (e < tbl_used && tbl_key[e] != r.client_key)
				e++;
			if (e < tbl_used) begin
				opened = 1'b0;
				if (!tbl_open[e]) begin
					opened = 1'b1;
				end else if (64'(tbl_seen[e]) + 64'(gap_now) < 64'(r.timestamp)) begin
					end_session(e);
					opened = 1'b1;
				end else begin
					tbl_seen[e] = r.timestamp;
				end
				if (opened)
					begin_session(e, r.timestamp);
				o = entry_report(e);
				o.new_session = opened;
			end else if (tbl_used >= DEPTH) begin
				o.status = ST_FULL;
			end else begin
				e = tbl_used;
				tbl_key[e] = r.client_key;
				tbl_total[e] = '0;
				tbl_visits[e] = '0;
				begin_session(e, r.timestamp);
				tbl_used++;
				o = entry_report(e);
				o.new_client = 1'b1;
				o.new_session = 1'b1;
			end
		end
		o.entry_count = CNT_OUT_W'(tbl_used);
		return o;
	endfunction

	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 16);
		return $urandom_range(40, 120);
	endfunction

	// mostly inside the gap, some just past it, a few backwards or anywhere
	function automatic logic [TIME_W-1:0] later_stamp(logic [TIME_W-1:0] prev);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return TIME_W'(64'(prev) + 64'($urandom_range(0, gap_now)));
		if (roll < 80)
			return TIME_W'(64'(prev) + 64'(gap_now) + 64'($urandom_range(1, 3)));
		if (roll < 90)
			return prev - TIME_W'($urandom_range(0, 1000));
		return TIME_W'($urandom);
	endfunction

	task automatic push_hit(logic [KEY_W-1:0] k, logic [TIME_W-1:0] t);
		req_t r;
		r.kind = KIND_HIT;
		r.client_key = k;
		r.timestamp = t;
		r.read_index = RIDX_W'($urandom);
		if (key_clock.exists(k)) begin
			key_clock[k] = t;
		end else if (known_keys.size() < DEPTH) begin
			known_keys.push_back(k);
			key_clock[k] = t;
		end
		queued_requests.push_back(r);
	endtask

	task automatic push_read(logic [RIDX_W-1:0] idx);
		req_t r;
		r.kind = KIND_READ;
		r.client_key = KEY_W'($urandom);
		r.timestamp = TIME_W'($urandom);
		r.read_index = idx;
		queued_requests.push_back(r);
	endtask

	task automatic make_random(int n);
		logic [KEY_W-1:0] k;
		repeat (n) begin
			if ($urandom_range(0, 99) < 20) begin
				if (known_keys.size() != 0 && $urandom_range(0, 4) != 0)
					push_read(RIDX_W'($urandom_range(0, known_keys.size() - 1)));
				else
					push_read(RIDX_W'($urandom));
			end else if (known_keys.size() == 0 ||
					$urandom_range(0, 99) < (known_keys.size() < DEPTH ? 75 : 10)) begin
				do
					k = KEY_W'($urandom);
				while (key_clock.exists(k));
				push_hit(k, TIME_W'($urandom));
			end else begin
				k = known_keys[$urandom_range(0, known_keys.size() - 1)];
				push_hit(k, later_stamp(key_clock[k]));
			end
		end
	endtask

	task automatic set_gap(logic [GAP_W-1:0] g);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_we <= 1'b0;
		gap_now = g;
	endtask

	task automatic wait_idle();
		while (queued_requests.size() != 0 || req_valid || due_reports.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failed = 1'b1;
		end
	endtask

	// request driver
	int send_wait = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_wait <= 0;
		end else begin
			if (req_valid && req_ready)
				due_reports.push_back(advance_sessions(req));
			if (!req_valid || req_ready) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					req_valid <= 1'b0;
				end else if (queued_requests.size() != 0) begin
					req <= queued_requests.pop_front();
					req_valid <= 1'b1;
					send_wait <= idle_cycles();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// report monitor
	int hold_left      = 0;
	int reports_seen   = 0;
	bit long_hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				reports_seen <= reports_seen + 1;
				if (due_reports.size() == 0) begin
					$error("report with no request outstanding");
					failed = 1'b1;
				end else begin
					next_report = due_reports.pop_front();
					check_field("status", next_report.status, rsp.status);
					check_field("entry_index", next_report.entry_index, rsp.entry_index);
					check_field("new_client", next_report.new_client, rsp.new_client);
					check_field("new_session", next_report.new_session, rsp.new_session);
					check_field("entry_key", next_report.entry_key, rsp.entry_key);
					check_field("visit_count", next_report.visit_count, rsp.visit_count);
					check_field("elapsed_seconds", next_report.elapsed_seconds,
						rsp.elapsed_seconds);
					check_field("elapsed_hours", next_report.elapsed_hours, rsp.elapsed_hours);
					check_field("entry_count", next_report.entry_count, rsp.entry_count);
				end
			end
			// one long back-pressure stretch so the request side stalls
			if (reports_seen == 60 && !long_hold_done) begin
				long_hold_done <= 1'b1;
				hold_left <= 2000;
				rsp_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				rsp_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				hold_left <= idle_cycles();
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [GAP_W-1:0] more_gaps[4];
		more_gaps[0] = GAP_W'($urandom_range(2, 3600));
		more_gaps[1] = 16'd1;
		more_gaps[2] = GAP_W'($urandom);
		more_gaps[3] = GAP_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		push_read(9'd0);
		push_read(9'd511);
		push_hit(32'h0000_0000, 32'd100);
		push_hit(32'hFFFF_FFFF, 32'hFFFF_FFF0);
		push_hit(32'hFFFF_FFFF, 32'hFFFF_FFFF);	// limit sum passes 2^32
		push_hit(32'h0000_0000, 32'd132);	// right at the limit
		push_hit(32'h0000_0000, 32'd165);	// one past
		push_hit(32'h0000_0000, 32'd50);	// clock steps back
		push_hit(32'h0000_0000, 32'd5000);	// closes with nothing added
		push_read(9'd0);
		push_hit(32'h0000_0000, 32'd5000);
		push_hit(32'h0000_0000, 32'd5030);
		push_read(9'd0);
		push_read(9'd1);
		push_read(9'd2);
		push_hit(32'hA5A5_A5A5, 32'd0);
		push_hit(32'h5A5A_5A5A, 32'h8000_0000);
		push_read(9'd2);
		wait_idle();

		set_gap('0);
		push_hit(32'hA5A5_A5A5, 32'd0);
		push_hit(32'hA5A5_A5A5, 32'd1);
		make_random(RANDOM_PER_PHASE);
		wait_idle();

		set_gap('1);
		push_hit(32'h5A5A_5A5A, 32'h8000_FFFF);
		push_hit(32'h5A5A_5A5A, 32'h8002_0000);
		push_read(9'd3);
		make_random(RANDOM_PER_PHASE);
		wait_idle();

		for (int p = 0; p < 4; p++) begin
			steady <= (p == 1);
			set_gap(more_gaps[p]);
			make_random(RANDOM_PER_PHASE);
			wait_idle();
		end

		repeat (600) @(posedge clk);
		if (!failed)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/cst_pkg.sv
hw/rtl/cst_ram.sv
hw/rtl/cst_div.sv
hw/rtl/client_session_tracker.sv
tb/client_session_tracker_tb.sv
